FILE: hdl/text_value_histogram_binner_core_assert.svh
// assertion macros used by the checker file
`ifndef TEXT_VALUE_HISTOGRAM_BINNER_CORE_ASSERT_SVH
`define TEXT_VALUE_HISTOGRAM_BINNER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TVHB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvhb assertion failed");

// next-cycle implication, disabled during reset
`define TVHB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvhb assertion failed");

`endif

FILE: hdl/tvhb_pkg.sv
// types and constants of the text value histogram binner
`timescale 1ns / 1ps
package tvhb_pkg;

   localparam int VAL_W  = 31;
   localparam int NEFF_W = 7;

   localparam logic [VAL_W-1:0] SAT_MAX = 31'h7FFF_FFFF;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic             kind;
      logic [7:0]       text_byte;
      logic [4:0]       bound_slot;
      logic [VAL_W-1:0] bound_value;
   } req_type;

   typedef struct packed {
      logic [4:0]       bucket_index;
      logic [VAL_W-1:0] bucket_total;
      logic             last;
      logic             format_error;
   } rsp_type;

   typedef struct packed {
      logic              commit;
      logic [VAL_W-1:0]  value;
      logic [VAL_W-1:0]  count;
      logic [NEFF_W-1:0] n_eff;
      logic              shift;
      logic              clear;
      logic              bound_we;
      logic [4:0]        bound_slot;
      logic [VAL_W-1:0]  bound_value;
   } cell_ctrl_type;

endpackage

FILE: hdl/tvhb_cell.sv
// one histogram bucket: lower bound, saturating count, priority and shift links
`timescale 1ns / 1ps
module tvhb_cell #(
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tvhb_pkg::cell_ctrl_type    ctrl,
   input  logic                       above_in,
   output logic                       above_out,
   input  logic [tvhb_pkg::VAL_W-1:0] upper_total,
   output logic [tvhb_pkg::VAL_W-1:0] total
);

   logic [tvhb_pkg::VAL_W-1:0] bound_ff, bound_in;
   logic [tvhb_pkg::VAL_W-1:0] count_ff, count_in;
   logic                       hit;
   logic                       sel;
   logic [tvhb_pkg::VAL_W:0]   sum;

   // bucket 0 catches everything no higher active bucket takes
   always_comb begin
      if (IDX == 0) begin
         hit = 1'b1;
      end else begin
         hit = (tvhb_pkg::NEFF_W'(IDX) < ctrl.n_eff) && (ctrl.value >= bound_ff);
      end
   end

   assign above_out = above_in | hit;
   assign sel       = hit & ~above_in;
   assign sum       = {1'b0, count_ff} + {1'b0, ctrl.count};
   assign total     = count_ff;

   always_comb begin
      bound_in = bound_ff;
      if (ctrl.bound_we && (7'(ctrl.bound_slot) == 7'(IDX))) begin
         bound_in = ctrl.bound_value;
      end
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.shift) begin
         count_in = upper_total;
      end else if (ctrl.commit && sel) begin
         count_in = sum[tvhb_pkg::VAL_W] ? tvhb_pkg::SAT_MAX : sum[tvhb_pkg::VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= '0;
         count_ff <= '0;
      end else begin
         bound_ff <= bound_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/text_value_histogram_binner_core.sv
// Text value histogram binner top level: token parser, report control and the bucket cell row.
// A request is taken in every cycle while no result is pending; a bound write or a text byte
// inside a line is taken without a stall. A line end holds off requests for the report, which
// shifts the bucket counts down the cell row one bucket per accepted result; an unexpected
// character holds requests for one error result. Each token is binned in the cycle its ending
// byte arrives, all cells comparing against their bounds in parallel.
`timescale 1ns / 1ps
module text_value_histogram_binner_core #(
   parameter int BUCKETS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tvhb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tvhb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [5:0]        csr_data
);

   localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   localparam logic [1:0] PH_REST  = 2'd0;
   localparam logic [1:0] PH_VALUE = 2'd1;
   localparam logic [1:0] PH_COUNT = 2'd2;
   localparam logic [1:0] PH_SKIP  = 2'd3;

   logic [5:0]                 csr_ff;
   logic [1:0]                 phase_ff, phase_in;
   logic [tvhb_pkg::VAL_W-1:0] value_ff, value_in;
   logic [tvhb_pkg::VAL_W-1:0] count_ff, count_in;
   logic                       rep_ff, rep_in;
   logic                       err_ff, err_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;

   logic [tvhb_pkg::NEFF_W-1:0] n_eff;
   logic                        req_fire, rsp_fire, is_text;
   logic                        is_digit, is_sep, is_end;
   logic [3:0]                  digit;
   logic                        rep_last;
   tvhb_pkg::cell_ctrl_type     ctrl;

   logic                       above [BUCKETS+1];
   logic [tvhb_pkg::VAL_W-1:0] totals [BUCKETS+1];

   logic [34:0] val_mul, cnt_mul;
   logic [6:0]  idx_wide;

   // clamp the register into 1 .. BUCKETS
   always_comb begin
      if (csr_ff == 6'd0) begin
         n_eff = tvhb_pkg::NEFF_W'(1);
      end else if (7'(csr_ff) > 7'(BUCKETS)) begin
         n_eff = tvhb_pkg::NEFF_W'(BUCKETS);
      end else begin
         n_eff = 7'(csr_ff);
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = ~(rep_ff | err_ff);
   assign rsp_valid = rep_ff | err_ff;
   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign is_text   = req_fire & ~req_data.kind;

   assign is_digit = (req_data.text_byte >= tvhb_pkg::CH_ZERO) &&
                     (req_data.text_byte <= tvhb_pkg::CH_NINE);
   assign is_sep   = (req_data.text_byte == tvhb_pkg::CH_SPACE) ||
                     (req_data.text_byte == tvhb_pkg::CH_TAB);
   assign is_end   = (req_data.text_byte == tvhb_pkg::CH_NUL) ||
                     (req_data.text_byte == tvhb_pkg::CH_LF) ||
                     (req_data.text_byte == tvhb_pkg::CH_CR);
   assign digit    = 4'(req_data.text_byte - tvhb_pkg::CH_ZERO);

   // acc * 10 + digit, saturated later
   assign val_mul = (35'(value_ff) << 3) + (35'(value_ff) << 1) + 35'(digit);
   assign cnt_mul = (35'(count_ff) << 3) + (35'(count_ff) << 1) + 35'(digit);

   assign rep_last = (7'(idx_ff) == (n_eff - tvhb_pkg::NEFF_W'(1)));

   always_comb begin
      phase_in = phase_ff;
      value_in = value_ff;
      count_in = count_ff;
      rep_in   = rep_ff;
      err_in   = err_ff;
      idx_in   = idx_ff;

      ctrl             = '0;
      ctrl.value       = value_ff;
      ctrl.n_eff       = n_eff;
      ctrl.bound_we    = req_fire & req_data.kind;
      ctrl.bound_slot  = req_data.bound_slot;
      ctrl.bound_value = req_data.bound_value;

      if (is_text) begin
         if (phase_ff == PH_SKIP) begin
            if (is_end) begin
               phase_in = PH_REST;
            end
         end else if (is_digit) begin
            case (phase_ff)
               PH_REST: begin
                  phase_in = PH_VALUE;
                  value_in = 31'(digit);
               end
               PH_VALUE: begin
                  value_in = (val_mul > 35'(tvhb_pkg::SAT_MAX)) ? tvhb_pkg::SAT_MAX
                                                                : val_mul[30:0];
               end
               default: begin
                  count_in = (cnt_mul > 35'(tvhb_pkg::SAT_MAX)) ? tvhb_pkg::SAT_MAX
                                                                : cnt_mul[30:0];
               end
            endcase
         end else if ((req_data.text_byte == tvhb_pkg::CH_STAR) && (phase_ff == PH_VALUE)) begin
            phase_in = PH_COUNT;
            count_in = '0;
         end else if (is_sep || is_end) begin
            ctrl.commit = (phase_ff == PH_VALUE) || (phase_ff == PH_COUNT);
            ctrl.count  = (phase_ff == PH_VALUE) ? 31'd1 : count_ff;
            phase_in    = PH_REST;
            value_in    = '0;
            count_in    = '0;
            if (is_end) begin
               rep_in = 1'b1;
               idx_in = '0;
            end
         end else begin
            // unexpected character: drop the line and report one error
            phase_in   = PH_SKIP;
            value_in   = '0;
            count_in   = '0;
            ctrl.clear = 1'b1;
            err_in     = 1'b1;
         end
      end

      if (rsp_fire) begin
         if (err_ff) begin
            err_in = 1'b0;
         end else begin
            ctrl.shift = 1'b1;
            idx_in     = IDX_W'(idx_ff + 1'b1);
            if (rep_last) begin
               rep_in     = 1'b0;
               ctrl.clear = 1'b1;
            end
         end
      end
   end

   assign idx_wide = 7'(idx_ff);

   always_comb begin
      if (err_ff) begin
         rsp_data.bucket_index = '0;
         rsp_data.bucket_total = '0;
         rsp_data.last         = 1'b1;
         rsp_data.format_error = 1'b1;
      end else begin
         rsp_data.bucket_index = idx_wide[4:0];
         rsp_data.bucket_total = totals[0];
         rsp_data.last         = rep_last;
         rsp_data.format_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff   <= 6'd32;
         phase_ff <= PH_REST;
         value_ff <= '0;
         count_ff <= '0;
         rep_ff   <= 1'b0;
         err_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (csr_valid) begin
            csr_ff <= csr_data;
         end
         phase_ff <= phase_in;
         value_ff <= value_in;
         count_ff <= count_in;
         rep_ff   <= rep_in;
         err_ff   <= err_in;
         idx_ff   <= idx_in;
      end
   end

   assign above[BUCKETS]  = 1'b0;
   assign totals[BUCKETS] = '0;

   for (genvar k = 0; k < BUCKETS; k++) begin : g_cell
      tvhb_cell #(
         .IDX(k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .above_in    (above[k+1]),
         .above_out   (above[k]),
         .upper_total (totals[k+1]),
         .total       (totals[k])
      );
   end

endmodule

FILE: hdl/tvhb_checker.sv
// port-level checker for the histogram binner, bound to the top level
`timescale 1ns / 1ps
`include "text_value_histogram_binner_core_assert.svh"
module tvhb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tvhb_pkg::rsp_type rsp_data
);

   logic rsp_fire;
   assign rsp_fire = rsp_valid & rsp_ready;

   // a stalled result holds
   `TVHB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))

   // no request is taken while a result is pending
   `TVHB_ASSERT_NOW(a_no_req_in_report, clock, reset, rsp_valid, !req_ready)

   // an error result is a lone empty one
   `TVHB_ASSERT_NOW(a_err_shape, clock, reset, rsp_valid && rsp_data.format_error,
      rsp_data.last && (rsp_data.bucket_total == 31'd0) && (rsp_data.bucket_index == 5'd0))

   // a report runs on without gaps until last
   `TVHB_ASSERT_NEXT(a_report_runs, clock, reset, rsp_fire && !rsp_data.last,
      rsp_valid && !rsp_data.format_error)

   // bucket indexes count up across a report
   `TVHB_ASSERT_NEXT(a_index_step, clock, reset, rsp_fire && !rsp_data.last,
      rsp_data.bucket_index == 5'($past(rsp_data.bucket_index) + 5'd1))

endmodule

bind text_value_histogram_binner_core tvhb_checker u_tvhb_checker (.*);
